[hw/rtl/cpgs_pkg.sv]
// constants shared by the cruise controller: opcodes, register indexes, reset values
`timescale 1ns / 1ps
`default_nettype none

package cpgs_pkg;

    // request opcodes
    localparam logic [1:0] OP_SPEED  = 2'd0;
    localparam logic [1:0] OP_DRIVER = 2'd1;
    localparam logic [1:0] OP_CORR   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_SHIFT_ONE   = 3'd0;
    localparam logic [2:0] REG_SHIFT_TWO   = 3'd1;
    localparam logic [2:0] REG_SHIFT_THREE = 3'd2;
    localparam logic [2:0] REG_SHIFT_FOUR  = 3'd3;
    localparam logic [2:0] REG_SHIFT_FIVE  = 3'd4;
    localparam logic [2:0] REG_SHIFT_SIX   = 3'd5;
    localparam logic [2:0] REG_MARGIN      = 3'd6;

    // register reset values (q8.8 shift speeds)
    localparam logic [15:0] SHIFT_ONE_RST   = 16'd8551;
    localparam logic [15:0] SHIFT_TWO_RST   = 16'd11499;
    localparam logic [15:0] SHIFT_THREE_RST = 16'd14499;
    localparam logic [15:0] SHIFT_FOUR_RST  = 16'd17833;
    localparam logic [15:0] SHIFT_FIVE_RST  = 16'd19850;
    localparam logic [15:0] SHIFT_SIX_RST   = 16'd21655;
    localparam logic [7:0]  MARGIN_RST      = 8'd4;

    // pi law limits
    localparam logic signed [12:0] INTEG_MAX = 13'sd2000;
    localparam logic signed [12:0] INTEG_MIN = -13'sd2000;
    localparam logic [6:0]         ACCEL_MAX = 7'd100;

    // divide by 20 as multiply by 3277 / 2^16, exact for magnitudes up to 2000
    localparam logic [11:0] RECIP_20 = 12'd3277;

endpackage

`default_nettype wire

[hw/rtl/cruise_pi_with_gear_schedule.sv]
// cruise controller top level: pi speed law, pedal pass-through and gear shift schedule
//
// channel  | handshake                     | payload
// ---------+-------------------------------+--------------------------------------------
// in       | s_axis_tvalid / s_axis_tready | s_axis_tdata, s_axis_tuser (opcode)
// out      | m_axis_tvalid / m_axis_tready | m_axis_tdata (accel, gear, clutch)
// config   | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// each request is registered on acceptance and processed from the input register;
// a speed request's command is then registered in the output register.
// one request per cycle is sustained; a speed request waits in the input register,
// stalling the input side, only while a command is held and m_axis_tready is low.
// rst_n clears valids and controller state, loads defaults; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module cruise_pi_with_gear_schedule #(
    parameter int TOP_GEAR = 7
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // vehicle_speed[7:0], pedal_accel[15:8], lever_gear[19:16], pedal_clutch[27:20],
    // cruise_button[28], correction_value[36:29]
    input  wire logic [39:0] s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // accel_command[6:0], gear_command[10:7], clutch_command[18:11]
    output logic [23:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int GEAR_W = $clog2(TOP_GEAR + 1) + 1;
    localparam int CMP_W  = (GEAR_W + 1 > 4) ? GEAR_W + 1 : 4;

    // configuration registers
    logic [15:0] shift_speed_one_reg;
    logic [15:0] shift_speed_two_reg;
    logic [15:0] shift_speed_three_reg;
    logic [15:0] shift_speed_four_reg;
    logic [15:0] shift_speed_five_reg;
    logic [15:0] shift_speed_six_reg;
    logic [7:0]  downshift_margin_reg;

    // input register
    logic        in_vld_reg;
    logic [1:0]  in_op_reg;
    logic [36:0] in_data_reg;

    // controller state
    logic                      cruise_engaged_reg;
    logic                      cruise_engaged_next;
    logic signed [7:0]         target_speed_reg;
    logic signed [7:0]         target_speed_next;
    logic signed [11:0]        error_integral_reg;
    logic signed [11:0]        error_integral_next;
    logic signed [GEAR_W-1:0]  current_gear_reg;
    logic signed [GEAR_W-1:0]  current_gear_next;
    logic signed [7:0]         last_speed_reg;
    logic [7:0]                held_pedal_accel_reg;
    logic signed [3:0]         held_lever_gear_reg;
    logic [7:0]                held_pedal_clutch_reg;
    logic [7:0]                accel_correction_reg;

    // output register
    logic        out_vld_reg;
    logic [6:0]  out_accel_reg;
    logic [3:0]  out_gear_reg;
    logic [7:0]  out_clutch_reg;

    // unpacked input fields
    logic signed [7:0] in_speed;
    logic [7:0]        in_pedal;
    logic signed [3:0] in_lever;
    logic [7:0]        in_clutch;
    logic              in_button;
    logic [7:0]        in_corr;

    logic is_speed;
    logic is_drv;
    logic is_corr;
    logic out_free;
    logic proc_go;

    // gear schedule
    logic signed [7:0]       speed_now;
    logic signed [CMP_W-1:0] gx;
    logic                    g_pos;
    logic [2:0]              idx_up;
    logic [2:0]              idx_dn;
    logic [15:0]             thr_up;
    logic [15:0]             thr_dn;
    logic signed [16:0]      up_lhs;
    logic signed [9:0]       dn_sum;
    logic signed [17:0]      dn_lhs;
    logic                    shift_up;
    logic                    shift_dn;
    logic signed [CMP_W-1:0] ng;
    logic signed [GEAR_W-1:0] sched_gear;
    logic                    lever_rev;
    logic signed [GEAR_W-1:0] manual_gear;

    // pi law
    logic signed [9:0]  err;
    logic signed [12:0] integ_sum;
    logic signed [11:0] integ_clamped;
    logic signed [11:0] integ_neg;
    logic [10:0]        integ_abs;
    logic [22:0]        quot_prod;
    logic [6:0]         quot;
    logic signed [7:0]  quot_s;
    logic signed [11:0] five_err;
    logic signed [11:0] pi_sum;
    logic [6:0]         pi_accel;
    logic [8:0]         pre_accel;
    logic signed [9:0]  corr_diff;
    logic [6:0]         final_accel;

    function automatic logic [15:0] pick_thr(input logic [2:0] idx,
                                             input logic [15:0] s1, input logic [15:0] s2,
                                             input logic [15:0] s3, input logic [15:0] s4,
                                             input logic [15:0] s5, input logic [15:0] s6);
        logic [15:0] thr;
        unique case (idx)
            cpgs_pkg::REG_SHIFT_ONE:   thr = s1;
            cpgs_pkg::REG_SHIFT_TWO:   thr = s2;
            cpgs_pkg::REG_SHIFT_THREE: thr = s3;
            cpgs_pkg::REG_SHIFT_FOUR:  thr = s4;
            cpgs_pkg::REG_SHIFT_FIVE:  thr = s5;
            default:                   thr = s6;
        endcase
        return thr;
    endfunction

    assign in_speed  = signed'(in_data_reg[7:0]);
    assign in_pedal  = in_data_reg[15:8];
    assign in_lever  = signed'(in_data_reg[19:16]);
    assign in_clutch = in_data_reg[27:20];
    assign in_button = in_data_reg[28];
    assign in_corr   = in_data_reg[36:29];

    assign is_speed = (in_op_reg == cpgs_pkg::OP_SPEED);
    assign is_drv   = (in_op_reg == cpgs_pkg::OP_DRIVER);
    assign is_corr  = (in_op_reg == cpgs_pkg::OP_CORR);

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign proc_go       = in_vld_reg && (!is_speed || out_free);
    assign s_axis_tready = !in_vld_reg || proc_go;
    assign cfg_ready     = 1'b1;

    // gear schedule, shared by the speed and driver requests
    always_comb
    begin
        speed_now = is_speed ? in_speed : last_speed_reg;
        gx        = CMP_W'(current_gear_reg);
        g_pos     = gx > $signed(CMP_W'(0));
        idx_up    = (gx > $signed(CMP_W'(6))) ? cpgs_pkg::REG_SHIFT_SIX : 3'(gx - CMP_W'(1));
        idx_dn    = (gx > $signed(CMP_W'(7))) ? cpgs_pkg::REG_SHIFT_SIX : 3'(gx - CMP_W'(2));
        thr_up    = pick_thr(idx_up, shift_speed_one_reg, shift_speed_two_reg,
                             shift_speed_three_reg, shift_speed_four_reg,
                             shift_speed_five_reg, shift_speed_six_reg);
        thr_dn    = pick_thr(idx_dn, shift_speed_one_reg, shift_speed_two_reg,
                             shift_speed_three_reg, shift_speed_four_reg,
                             shift_speed_five_reg, shift_speed_six_reg);
        up_lhs    = signed'({speed_now[7], speed_now, 8'h00});
        shift_up  = up_lhs > signed'({1'b0, thr_up});
        dn_sum    = 10'(speed_now) + signed'({2'b00, downshift_margin_reg});
        dn_lhs    = signed'({dn_sum, 8'h00});
        shift_dn  = (gx > $signed(CMP_W'(1))) && (dn_lhs < signed'({2'b00, thr_dn}));
        if (!g_pos)
        begin
            ng = CMP_W'(1);
        end
        else if (shift_up)
        begin
            ng = gx + CMP_W'(1);
        end
        else if (shift_dn)
        begin
            ng = gx - CMP_W'(1);
        end
        else
        begin
            ng = gx;
        end
        if (ng > $signed(CMP_W'(TOP_GEAR)))
        begin
            ng = CMP_W'(TOP_GEAR);
        end
        sched_gear  = GEAR_W'(ng);
        lever_rev   = (is_drv ? in_lever : held_lever_gear_reg) == -4'sd1;
        manual_gear = lever_rev ? -GEAR_W'(1) : sched_gear;
    end

    // pi law and accelerator command
    always_comb
    begin
        err       = 10'(target_speed_reg) - 10'(in_speed);
        integ_sum = 13'(error_integral_reg) + 13'(err);
        if (integ_sum > cpgs_pkg::INTEG_MAX)
        begin
            integ_clamped = 12'(cpgs_pkg::INTEG_MAX);
        end
        else if (integ_sum < cpgs_pkg::INTEG_MIN)
        begin
            integ_clamped = 12'(cpgs_pkg::INTEG_MIN);
        end
        else
        begin
            integ_clamped = 12'(integ_sum);
        end
        integ_neg = -integ_clamped;
        integ_abs = integ_clamped[11] ? integ_neg[10:0] : integ_clamped[10:0];
        quot_prod = 23'(integ_abs) * 23'(cpgs_pkg::RECIP_20);
        quot      = quot_prod[22:16];
        quot_s    = integ_clamped[11] ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
        five_err  = signed'({err, 2'b00}) + 12'(err);
        pi_sum    = five_err + 12'(quot_s);
        if (pi_sum < 12'sd0)
        begin
            pi_accel = 7'd0;
        end
        else if (pi_sum > signed'({5'b0, cpgs_pkg::ACCEL_MAX}))
        begin
            pi_accel = cpgs_pkg::ACCEL_MAX;
        end
        else
        begin
            pi_accel = pi_sum[6:0];
        end
        pre_accel = cruise_engaged_reg ? {2'b00, pi_accel} : {1'b0, held_pedal_accel_reg};
        corr_diff = signed'({1'b0, pre_accel}) - signed'({2'b00, accel_correction_reg});
        if (corr_diff < 10'sd0)
        begin
            final_accel = 7'd0;
        end
        else if (corr_diff > signed'({3'b0, cpgs_pkg::ACCEL_MAX}))
        begin
            final_accel = cpgs_pkg::ACCEL_MAX;
        end
        else
        begin
            final_accel = corr_diff[6:0];
        end
    end

    // next state for the request in the input register
    always_comb
    begin
        cruise_engaged_next = cruise_engaged_reg;
        target_speed_next   = target_speed_reg;
        error_integral_next = error_integral_reg;
        current_gear_next   = current_gear_reg;
        if (is_drv)
        begin
            if (in_button && (last_speed_reg > 8'sd0))
            begin
                if (!cruise_engaged_reg)
                begin
                    cruise_engaged_next = 1'b1;
                    target_speed_next   = last_speed_reg;
                    error_integral_next = 12'sd0;
                end
            end
            else
            begin
                cruise_engaged_next = 1'b0;
                target_speed_next   = -8'sd1;
            end
            if (!cruise_engaged_next)
            begin
                current_gear_next = manual_gear;
            end
        end
        else if (is_speed)
        begin
            if (cruise_engaged_reg)
            begin
                error_integral_next = integ_clamped;
                current_gear_next   = sched_gear;
            end
            else
            begin
                current_gear_next = manual_gear;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_speed_one_reg   <= cpgs_pkg::SHIFT_ONE_RST;
            shift_speed_two_reg   <= cpgs_pkg::SHIFT_TWO_RST;
            shift_speed_three_reg <= cpgs_pkg::SHIFT_THREE_RST;
            shift_speed_four_reg  <= cpgs_pkg::SHIFT_FOUR_RST;
            shift_speed_five_reg  <= cpgs_pkg::SHIFT_FIVE_RST;
            shift_speed_six_reg   <= cpgs_pkg::SHIFT_SIX_RST;
            downshift_margin_reg  <= cpgs_pkg::MARGIN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cpgs_pkg::REG_SHIFT_ONE:   shift_speed_one_reg   <= cfg_data;
                cpgs_pkg::REG_SHIFT_TWO:   shift_speed_two_reg   <= cfg_data;
                cpgs_pkg::REG_SHIFT_THREE: shift_speed_three_reg <= cfg_data;
                cpgs_pkg::REG_SHIFT_FOUR:  shift_speed_four_reg  <= cfg_data;
                cpgs_pkg::REG_SHIFT_FIVE:  shift_speed_five_reg  <= cfg_data;
                cpgs_pkg::REG_SHIFT_SIX:   shift_speed_six_reg   <= cfg_data;
                cpgs_pkg::REG_MARGIN:      downshift_margin_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg   <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[36:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_engaged_reg    <= 1'b0;
            target_speed_reg      <= -8'sd1;
            error_integral_reg    <= 12'sd0;
            current_gear_reg      <= '0;
            last_speed_reg        <= 8'sd0;
            held_pedal_accel_reg  <= 8'd0;
            held_lever_gear_reg   <= 4'sd0;
            held_pedal_clutch_reg <= 8'd0;
            accel_correction_reg  <= 8'd0;
        end
        else if (proc_go)
        begin
            cruise_engaged_reg <= cruise_engaged_next;
            target_speed_reg   <= target_speed_next;
            error_integral_reg <= error_integral_next;
            current_gear_reg   <= current_gear_next;
            if (is_speed)
            begin
                last_speed_reg <= in_speed;
            end
            if (is_drv)
            begin
                held_pedal_accel_reg  <= in_pedal;
                held_lever_gear_reg   <= in_lever;
                held_pedal_clutch_reg <= in_clutch;
            end
            if (is_corr)
            begin
                accel_correction_reg <= in_corr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (proc_go && is_speed)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && is_speed)
        begin
            out_accel_reg  <= final_accel;
            out_gear_reg   <= current_gear_next[3:0];
            out_clutch_reg <= cruise_engaged_reg ? 8'd0 : held_pedal_clutch_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'b00000, out_clutch_reg, out_gear_reg, out_accel_reg};

    // engaged cruise always holds a positive set speed
    a_engaged_target: assert property (@(posedge clk) disable iff (!rst_n)
        cruise_engaged_reg |-> (target_speed_reg > 8'sd0))
        else $error("engaged cruise without a positive set speed");

    // released cruise always parks the set speed at minus one
    a_released_target: assert property (@(posedge clk) disable iff (!rst_n)
        !cruise_engaged_reg |-> (target_speed_reg == -8'sd1))
        else $error("released cruise with a live set speed");

    // integrator stays inside its clamp
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (error_integral_reg <= 12'sd2000) && (error_integral_reg >= -12'sd2000))
        else $error("integrator outside its clamp");

    // gear stays between reverse and the top gear
    a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
        (current_gear_reg >= -GEAR_W'(1)) &&
        (CMP_W'(current_gear_reg) <= $signed(CMP_W'(TOP_GEAR))))
        else $error("gear outside the schedule range");

    // a held command never exceeds full throttle
    a_accel_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= cpgs_pkg::ACCEL_MAX))
        else $error("accelerator command above full throttle");

endmodule

`default_nettype wire

[verif/cruise_pi_with_gear_schedule_tb.sv]
// self-checking stream testbench for cruise_pi_with_gear_schedule: directed and random requests
`timescale 1ns / 1ps

module cruise_pi_with_gear_schedule_tb;

    localparam int TOP_GEAR = 7;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_REQUESTS = 190;
    localparam int PRINT_LIMIT = 50;
    localparam logic [15:0] SHIFT_RST [6] = '{cpgs_pkg::SHIFT_ONE_RST, cpgs_pkg::SHIFT_TWO_RST,
                                              cpgs_pkg::SHIFT_THREE_RST,
                                              cpgs_pkg::SHIFT_FOUR_RST,
                                              cpgs_pkg::SHIFT_FIVE_RST,
                                              cpgs_pkg::SHIFT_SIX_RST};

    typedef struct packed {
        logic [1:0]        op;
        logic signed [7:0] speed;
        logic [7:0]        pedal;
        logic signed [3:0] lever;
        logic [7:0]        clutch;
        logic              button;
        logic [7:0]        corr;
    } cruise_req_t;

    typedef struct packed {
        logic [6:0]        accel;
        logic signed [3:0] gear;
        logic [7:0]        clutch;
    } cruise_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // predicted controller state
    logic               cc_engaged;
    logic signed [7:0]  cc_target;
    logic signed [11:0] cc_integral;
    logic signed [3:0]  cc_gear;
    logic signed [7:0]  cc_speed;
    logic [7:0]         cc_pedal;
    logic signed [3:0]  cc_lever;
    logic [7:0]         cc_clutch;
    logic [7:0]         cc_corr;
    logic [15:0]        shift_spd [6];
    logic [7:0]         down_margin;

    cruise_req_t req_pending[$];
    cruise_cmd_t cmd_expected[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int queued_count = 0;
    int requests_taken = 0;
    int cmds_checked = 0;
    int reg_writes = 0;
    int engage_count = 0;
    int fail_count = 0;
    int quiet_cycles = 0;
    int rx_hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;

    cruise_pi_with_gear_schedule #(
        .TOP_GEAR(TOP_GEAR)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int limit(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int shift_point(input int g);
        return int'(shift_spd[((g > 6) ? 6 : g) - 1]);
    endfunction

    function automatic int scheduled_gear(input int g);
        int ng;
        ng = g;
        if (g <= 0)
            ng = 1;
        else if (int'(cc_speed) * 256 > shift_point(g))
            ng = g + 1;
        else if (g > 1 && (int'(cc_speed) + int'(down_margin)) * 256 < shift_point(g - 1))
            ng = g - 1;
        return limit(ng, 0, TOP_GEAR);
    endfunction

    // gear while cruise is off: the lever at reverse overrides the schedule
    function automatic logic signed [3:0] manual_gear();
        return (cc_lever != -4'sd1) ? 4'(scheduled_gear(int'(cc_gear))) : -4'sd1;
    endfunction

    task automatic apply_request(input cruise_req_t r);
        int err;
        int accel;
        int clutch;
        cruise_cmd_t c;
        if (r.op == cpgs_pkg::OP_CORR)
            cc_corr = r.corr;
        else if (r.op == cpgs_pkg::OP_DRIVER)
        begin
            cc_pedal = r.pedal;
            cc_lever = r.lever;
            cc_clutch = r.clutch;
            if (r.button && cc_speed > 8'sd0)
            begin
                if (!cc_engaged)
                begin
                    cc_target = cc_speed;
                    cc_engaged = 1'b1;
                    cc_integral = '0;
                    engage_count++;
                end
            end
            else
            begin
                cc_engaged = 1'b0;
                cc_target = -8'sd1;
            end
            if (!cc_engaged)
                cc_gear = manual_gear();
        end
        else if (r.op == cpgs_pkg::OP_SPEED)
        begin
            cc_speed = r.speed;
            if (!cc_engaged)
            begin
                cc_gear = manual_gear();
                accel = int'(cc_pedal);
                clutch = int'(cc_clutch);
            end
            else
            begin
                err = int'(cc_target) - int'(cc_speed);
                cc_integral = 12'(limit(int'(cc_integral) + err, -2000, 2000));
                accel = limit(5 * err + int'(cc_integral) / 20, 0, 100);
                cc_gear = 4'(scheduled_gear(int'(cc_gear)));
                clutch = 0;
            end
            accel = limit(accel - int'(cc_corr), 0, 100);
            c.accel = 7'(accel);
            c.gear = cc_gear;
            c.clutch = 8'(clutch);
            cmd_expected.push_back(c);
        end
    endtask

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_command(input logic [23:0] d);
        cruise_cmd_t want;
        if (cmd_expected.size() == 0)
        begin
            report_mismatch($sformatf("command %h arrived with none expected", d));
            return;
        end
        want = cmd_expected.pop_front();
        cmds_checked++;
        if (d[6:0] != want.accel)
            report_mismatch($sformatf("command %0d accel: got %0d, want %0d",
                                      cmds_checked, d[6:0], want.accel));
        if (d[10:7] != want.gear)
            report_mismatch($sformatf("command %0d gear: got %0d, want %0d",
                                      cmds_checked, $signed(d[10:7]), want.gear));
        if (d[18:11] != want.clutch)
            report_mismatch($sformatf("command %0d clutch: got %0d, want %0d",
                                      cmds_checked, d[18:11], want.clutch));
    endtask

    function automatic cruise_req_t random_request();
        cruise_req_t r;
        case ($urandom_range(3))
            0: r.op = cpgs_pkg::OP_SPEED;
            1: r.op = cpgs_pkg::OP_DRIVER;
            2: r.op = cpgs_pkg::OP_CORR;
            default: r.op = OP_UNUSED;
        endcase
        r.speed = 8'($urandom_range(255));
        r.pedal = 8'($urandom_range(255));
        r.lever = 4'(int'($urandom_range(8)) - 1);
        r.clutch = 8'($urandom_range(255));
        r.button = 1'($urandom_range(1));
        r.corr = 8'($urandom_range(255));
        return r;
    endfunction

    task automatic post_request(input cruise_req_t r);
        req_pending.push_back(r);
        if (r.op != OP_UNUSED)
            queued_count++;
    endtask

    task automatic add_request(input logic [1:0] op, input logic signed [7:0] speed,
                               input logic [7:0] pedal, input logic signed [3:0] lever,
                               input logic [7:0] clutch, input logic button,
                               input logic [7:0] corr);
        cruise_req_t r;
        r.op = op;
        r.speed = speed;
        r.pedal = pedal;
        r.lever = lever;
        r.clutch = clutch;
        r.button = button;
        r.corr = corr;
        post_request(r);
    endtask

    // mostly engage / track / drop sequences around a held speed, the rest noise
    task automatic queue_random_requests(input int want);
        int stop;
        int tgt;
        int bias;
        int spd;
        int k;
        int runs;
        cruise_req_t r;
        stop = queued_count + want;
        while (queued_count < stop)
        begin
            if ($urandom_range(99) < 30)
            begin
                r = random_request();
                if (r.op == cpgs_pkg::OP_CORR && $urandom_range(1) == 0)
                    r.corr = 8'($urandom_range(20));
                post_request(r);
            end
            else
            begin
                tgt = int'($urandom_range(1, 127));
                r = random_request();
                r.op = cpgs_pkg::OP_SPEED;
                r.speed = 8'(tgt);
                post_request(r);
                if ($urandom_range(2) == 0)
                begin
                    r = random_request();
                    r.op = cpgs_pkg::OP_CORR;
                    r.corr = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(40));
                    post_request(r);
                end
                r = random_request();
                r.op = cpgs_pkg::OP_DRIVER;
                r.button = 1'b1;
                post_request(r);
                bias = ($urandom_range(7) == 0) ? int'($urandom_range(240)) - 120
                                                : int'($urandom_range(10)) - 5;
                runs = int'($urandom_range(3, 40));
                for (k = 0; k < runs; k++)
                begin
                    if ($urandom_range(11) == 0)
                    begin
                        r = random_request();
                        r.op = ($urandom_range(1) == 0) ? cpgs_pkg::OP_CORR
                                                        : cpgs_pkg::OP_DRIVER;
                        r.button = 1'b1;
                        r.corr = 8'($urandom_range(40));
                        post_request(r);
                    end
                    spd = ($urandom_range(15) == 0) ? int'($urandom_range(255)) - 128
                                                    : tgt - bias + int'($urandom_range(6)) - 3;
                    r = random_request();
                    r.op = cpgs_pkg::OP_SPEED;
                    r.speed = 8'(limit(spd, -128, 127));
                    post_request(r);
                end
                r = random_request();
                r.op = cpgs_pkg::OP_DRIVER;
                r.button = 1'b0;
                post_request(r);
                runs = int'($urandom_range(4));
                for (k = 0; k < runs; k++)
                begin
                    r = random_request();
                    r.op = cpgs_pkg::OP_SPEED;
                    post_request(r);
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (req_pending.size() != 0 || s_axis_tvalid || cmd_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need no second assignment
    task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == cpgs_pkg::REG_MARGIN)
            down_margin = val[7:0];
        else
            shift_spd[idx] = val;
        reg_writes++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(req_pending.pop_front());
                requests_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= req_pending[0].op;
                    s_axis_tdata <= {3'b000, req_pending[0].corr, req_pending[0].button,
                                     req_pending[0].clutch, req_pending[0].lever,
                                     req_pending[0].pedal, req_pending[0].speed};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // command monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_command(m_axis_tdata);
            m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            rx_hold_left <= LONG_HOLD;
            hold_seen <= hold_req;
        end
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
            $display("cruise_pi_with_gear_schedule test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int p;
        int k;
        int pts [6];
        int marg;
        cc_engaged = 1'b0;
        cc_target = -8'sd1;
        cc_integral = '0;
        cc_gear = '0;
        cc_speed = '0;
        cc_pedal = '0;
        cc_lever = '0;
        cc_clutch = '0;
        cc_corr = '0;
        for (k = 0; k < 6; k++)
            shift_spd[k] = SHIFT_RST[k];
        down_margin = cpgs_pkg::MARGIN_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored opcode, field extremes, gear limits, engage and drop
        add_request(OP_UNUSED, 8'sd127, 8'd255, 4'sd7, 8'd255, 1'b1, 8'd255);
        add_request(cpgs_pkg::OP_SPEED, 8'sd0, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_DRIVER, 8'sd0, 8'd255, 4'sd3, 8'd255, 1'b1, 8'd0);
        add_request(cpgs_pkg::OP_SPEED, 8'sh80, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_DRIVER, 8'sh80, 8'd200, 4'sd0, 8'd128, 1'b1, 8'd0);
        add_request(cpgs_pkg::OP_CORR, 8'sd0, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd255);
        add_request(cpgs_pkg::OP_SPEED, 8'sd127, 8'd255, 4'sd7, 8'd255, 1'b1, 8'd255);
        add_request(cpgs_pkg::OP_CORR, 8'sd0, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        for (k = 0; k < 6; k++)
            add_request(cpgs_pkg::OP_SPEED, 8'sd127, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_DRIVER, 8'sd0, 8'd0, -4'sd1, 8'd0, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_SPEED, 8'sd50, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_DRIVER, 8'sd0, 8'd90, 4'sd7, 8'd17, 1'b1, 8'd0);
        add_request(cpgs_pkg::OP_SPEED, 8'sd127, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_SPEED, 8'sh80, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_DRIVER, 8'sd0, 8'd10, -4'sd1, 8'd60, 1'b1, 8'd0);
        add_request(cpgs_pkg::OP_SPEED, 8'sd0, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_DRIVER, 8'sd0, 8'd30, 4'sd0, 8'd40, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_SPEED, 8'sd60, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        add_request(cpgs_pkg::OP_DRIVER, 8'sd0, 8'd30, 4'sd2, 8'd40, 1'b1, 8'd0);
        add_request(cpgs_pkg::OP_SPEED, 8'sd58, 8'd0, 4'sd0, 8'd0, 1'b0, 8'd0);
        wait_drained();

        for (p = 0; p < 6; p++)
        begin
            for (k = 0; k < 6; k++)
            begin
                case (p)
                    1: pts[k] = 0;
                    2: pts[k] = 65535;
                    3: pts[k] = int'($urandom_range(65535));
                    4: pts[k] = (k == 0) ? int'($urandom_range(2000, 9000))
                                         : pts[k - 1] + int'($urandom_range(1000, 5000));
                    default: pts[k] = int'(SHIFT_RST[k]);
                endcase
            end
            case (p)
                0: marg = int'(cpgs_pkg::MARGIN_RST);
                1: marg = 0;
                2: marg = 255;
                4: marg = int'($urandom_range(16));
                default: marg = int'($urandom_range(255));
            endcase
            write_register(cpgs_pkg::REG_SHIFT_ONE, 16'(pts[0]));
            write_register(cpgs_pkg::REG_SHIFT_TWO, 16'(pts[1]));
            write_register(cpgs_pkg::REG_SHIFT_THREE, 16'(pts[2]));
            write_register(cpgs_pkg::REG_SHIFT_FOUR, 16'(pts[3]));
            write_register(cpgs_pkg::REG_SHIFT_FIVE, 16'(pts[4]));
            write_register(cpgs_pkg::REG_SHIFT_SIX, 16'(pts[5]));
            write_register(cpgs_pkg::REG_MARGIN, 16'(marg));
            cfg_valid <= 1'b0;

            send_idle_pct = (p % 4 == 1) ? 55 : ((p % 4 == 3) ? 16 : 0);
            recv_stall_pct = (p % 4 == 2) ? 55 : ((p % 4 == 3) ? 16 : 0);
            if (p == 0)
                hold_req <= ~hold_req;
            queue_random_requests(PHASE_REQUESTS / 2);
            wait_drained();
            queue_random_requests(PHASE_REQUESTS / 2);
            wait_drained();
        end

        $display("ran %0d requests and checked %0d commands; cruise engaged %0d times",
                 requests_taken, cmds_checked, engage_count);
        $display("%0d register writes over default, zero, full-scale, random and rising thresholds",
                 reg_writes);
        if (fail_count == 0)
            $display("cruise_pi_with_gear_schedule test passed");
        else
            $display("cruise_pi_with_gear_schedule test failed");
        $finish;
    end

endmodule

[cruise_pi_with_gear_schedule.f]
hw/rtl/cpgs_pkg.sv
hw/rtl/cruise_pi_with_gear_schedule.sv
verif/cruise_pi_with_gear_schedule_tb.sv
